FILE: hw/rtl/periodic_task_and_soft_timer_scheduler_core_defines.svh
// Assertion macros for the scheduler core.
// Included by the top level; no other dependencies.
`ifndef PERIODIC_TASK_AND_SOFT_TIMER_SCHEDULER_CORE_DEFINES_SVH
`define PERIODIC_TASK_AND_SOFT_TIMER_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define PTS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define PTS_ASSERT_IMP(label, clk, rst_n, pre, post)
`define PTS_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: hw/rtl/pts_pkg.sv
// Shared types and constants of the scheduler core.
// No dependencies.
package pts_pkg;
    localparam int TASK_SLOTS  = 8;
    localparam int TIMER_SLOTS = 8;
    localparam int SLOT_W      = $clog2(TASK_SLOTS > TIMER_SLOTS ? TASK_SLOTS : TIMER_SLOTS);

    localparam logic [3:0] OP_TICK    = 4'd0;
    localparam logic [3:0] OP_PERIOD  = 4'd1;
    localparam logic [3:0] OP_TSTART  = 4'd2;
    localparam logic [3:0] OP_TSTOP   = 4'd3;
    localparam logic [3:0] OP_REG     = 4'd4;
    localparam logic [3:0] OP_RELOAD  = 4'd5;
    localparam logic [3:0] OP_MSTART  = 4'd6;
    localparam logic [3:0] OP_MSTOP   = 4'd7;
    localparam logic [3:0] OP_READ    = 4'd8;
    localparam logic [3:0] OP_RESTART = 4'd9;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_TASK  = 2'd1;
    localparam logic [1:0] KIND_TIMER = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [1:0] CFG_TICK  = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TASKS = 2'd2;
    localparam logic [1:0] CFG_TIMRS = 2'd3;

    typedef struct packed {
        logic start;
        logic done;
        logic zero;
    } t_mod_ctl;
endpackage

FILE: hw/rtl/pts_modulo.sv
// Bit-serial remainder unit: tests whether a 32-bit value is a multiple of a 16-bit divisor.
// Depends on pts_pkg.
module pts_modulo
    import pts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output t_mod_ctl    o_ctl
);
    logic [31:0] r_dvd;
    logic [16:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] w_sh;

    assign w_sh = {r_rem[15:0], r_dvd[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_dvd  <= i_dividend;
                r_rem  <= 17'd0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_rem <= (w_sh >= {1'b0, i_divisor}) ? w_sh - {1'b0, i_divisor} : w_sh;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl.start = r_busy;
    assign o_ctl.done  = r_done;
    assign o_ctl.zero  = (r_rem == 17'd0);
endmodule

FILE: hw/rtl/periodic_task_and_soft_timer_scheduler_core.sv
// Top level of the periodic task and software timer scheduler.
// Depends on pts_pkg, pts_modulo and the defines header.
//
// A tick walks the timer slots in use and then the task slots in use, one slot per cycle
// through a shared subtract and compare unit, and then gives its end-of-tick word. A
// tick past the run limit gives its halted word in the cycle after it is accepted. A
// command that checks a value replies after the bit-serial remainder unit is done; other
// commands reply without waiting for it. Results appear one per cycle with o_valid and
// must be taken at once, since the receiver cannot stall.
`include "periodic_task_and_soft_timer_scheduler_core_defines.svh"
module periodic_task_and_soft_timer_scheduler_core
    import pts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_op,
    input  logic [7:0]  i_id,
    input  logic [31:0] i_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic        o_ok,
    output logic [31:0] o_reading,
    output logic        o_halted,
    output logic        o_last
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_CMD  = 3'd2;
    localparam logic [2:0] S_TMR  = 3'd3;
    localparam logic [2:0] S_TSK  = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;

    logic [15:0] r_tick;
    logic [31:0] r_limit;
    logic [3:0]  r_ntask, r_ntimer;

    logic [31:0] r_run;
    logic [31:0] r_period  [TASK_SLOTS];
    logic [31:0] r_lastrun [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]  r_en;
    logic [31:0] r_tout    [TIMER_SLOTS];
    logic [31:0] r_rem     [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] r_runf;

    logic [2:0]  r_state;
    logic [3:0]  r_op;
    logic [7:0]  r_id;
    logic [31:0] r_val;
    logic [5:0]  r_idx;
    logic        r_modsent;
    logic        r_mult;

    logic        r_ov;
    logic [1:0]  r_okind;
    logic [3:0]  r_oslot;
    logic        r_ook, r_ohalt, r_olast;
    logic [31:0] r_oread;

    t_mod_ctl    w_mod;
    logic        w_accept;
    logic [3:0]  w_ut, w_um;
    logic        w_tv, w_mv;
    logic [SLOT_W-1:0] w_t, w_m, w_i;
    logic [32:0] w_sum;
    logic [31:0] w_sub;
    logic        w_isdone;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign w_ut = (r_ntask  > 4'(TASK_SLOTS))  ? 4'(TASK_SLOTS)  : r_ntask;
    assign w_um = (r_ntimer > 4'(TIMER_SLOTS)) ? 4'(TIMER_SLOTS) : r_ntimer;
    assign w_tv = (r_id != 8'd0) && (r_id <= {4'd0, w_ut});
    assign w_mv = (r_id != 8'd0) && (r_id <= {4'd0, w_um});
    assign w_t  = SLOT_W'(r_id - 8'd1);
    assign w_m  = w_t;
    assign w_i  = r_idx[SLOT_W-1:0];
    assign w_sum = {1'b0, r_run} + {17'd0, r_tick};

    pts_modulo u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_MOD && !r_modsent),
        .i_dividend (r_val),
        .i_divisor  (r_tick),
        .o_ctl      (w_mod)
    );

    always_comb begin
        if (r_state == S_TSK) w_sub = r_run - r_lastrun[w_i];
        else w_sub = r_rem[w_i];
    end
    assign w_isdone = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= 16'd1;
            r_limit  <= 32'hFFFF_FFFF;
            r_ntask  <= 4'd8;
            r_ntimer <= 4'd8;
            r_run    <= 32'd0;
            r_en     <= '0;
            r_runf   <= '0;
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_modsent <= 1'b0;
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_period[k]  <= 32'd0;
                r_lastrun[k] <= 32'd0;
            end
            for (int k = 0; k < TIMER_SLOTS; k++) begin
                r_tout[k] <= 32'd0;
                r_rem[k]  <= 32'd0;
            end
        end else begin
            r_ov <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TICK:  r_tick   <= i_cfg_data[15:0];
                    CFG_LIMIT: r_limit  <= i_cfg_data;
                    CFG_TASKS: r_ntask  <= i_cfg_data[3:0];
                    CFG_TIMRS: r_ntimer <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op  <= i_op;
                        r_id  <= i_id;
                        r_val <= i_value;
                        r_idx <= 6'd0;
                        r_modsent <= 1'b0;
                        if (i_op == OP_TICK) r_state <= S_TMR;
                        else if (i_op == OP_PERIOD || i_op == OP_REG || i_op == OP_RELOAD)
                            r_state <= S_MOD;
                        else r_state <= S_CMD;
                        r_mult <= 1'b1;
                        if (i_op == OP_TICK) begin
                            if (r_run >= r_limit) begin
                                r_state <= S_IDLE;
                                r_ov    <= 1'b1;
                                r_okind <= KIND_END;
                                r_oslot <= 4'd0;
                                r_ook   <= 1'b0;
                                r_oread <= r_run;
                                r_ohalt <= 1'b1;
                                r_olast <= 1'b1;
                            end else begin
                                r_run <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
                            end
                        end
                    end
                end
                S_MOD: begin
                    r_modsent <= 1'b1;
                    if (w_mod.done) begin
                        r_mult  <= (r_tick == 16'd0) ? (r_val == 32'd0) : w_mod.zero;
                        r_state <= S_CMD;
                    end
                end
                S_CMD: begin
                    r_ov    <= 1'b1;
                    r_okind <= KIND_REPLY;
                    r_oslot <= (r_id > 8'd15) ? 4'd15 : r_id[3:0];
                    r_ohalt <= 1'b0;
                    r_olast <= 1'b1;
                    r_oread <= 32'd0;
                    r_ook   <= 1'b0;
                    r_state <= S_IDLE;
                    case (r_op)
                        OP_PERIOD: begin
                            r_ook <= w_tv && r_mult;
                            if (w_tv && r_mult) r_period[w_t] <= r_val;
                        end
                        OP_TSTART: begin
                            r_ook <= w_tv;
                            if (w_tv) r_en[w_t] <= 1'b1;
                        end
                        OP_TSTOP: begin
                            r_ook <= w_tv;
                            if (w_tv) r_en[w_t] <= 1'b0;
                        end
                        OP_REG: begin
                            r_ook <= w_mv && r_mult && (r_val > {16'd0, r_tick});
                            if (w_mv && r_mult && (r_val > {16'd0, r_tick})) begin
                                r_tout[w_m] <= r_val;
                                r_rem[w_m]  <= r_val;
                                r_runf[w_m] <= 1'b0;
                            end
                        end
                        OP_RELOAD: begin
                            r_ook <= w_mv && r_mult;
                            if (w_mv && r_mult) begin
                                r_tout[w_m] <= r_val;
                                r_rem[w_m]  <= r_val;
                                r_runf[w_m] <= 1'b1;
                            end
                        end
                        OP_MSTART: begin
                            r_ook <= w_mv;
                            if (w_mv) begin
                                r_rem[w_m]  <= r_tout[w_m];
                                r_runf[w_m] <= 1'b1;
                            end
                        end
                        OP_MSTOP: begin
                            r_ook <= w_mv;
                            if (w_mv) r_runf[w_m] <= 1'b0;
                        end
                        OP_READ: begin
                            r_ook <= w_mv;
                            if (w_mv) r_oread <= r_rem[w_m];
                        end
                        OP_RESTART: begin
                            r_ook <= 1'b1;
                            r_run <= 32'd0;
                            for (int k = 0; k < TASK_SLOTS; k++) r_lastrun[k] <= 32'd0;
                        end
                        default: ;
                    endcase
                end
                S_TMR: begin
                    if (r_idx >= {2'd0, w_um}) begin
                        r_idx   <= 6'd0;
                        r_state <= S_TSK;
                    end else begin
                        r_idx <= r_idx + 6'd1;
                        if (r_runf[w_i]) begin
                            r_rem[w_i] <= (w_sub > {16'd0, r_tick}) ?
                                          w_sub - {16'd0, r_tick} : 32'd0;
                            if (w_sub <= {16'd0, r_tick}) begin
                                r_runf[w_i] <= 1'b0;
                                r_ov    <= 1'b1;
                                r_okind <= KIND_TIMER;
                                r_oslot <= 4'(r_idx + 6'd1);
                                r_ook   <= 1'b1;
                                r_oread <= 32'd0;
                                r_ohalt <= 1'b0;
                                r_olast <= 1'b0;
                            end
                        end
                    end
                end
                S_TSK: begin
                    if (r_idx >= {2'd0, w_ut}) begin
                        r_state <= S_END;
                    end else begin
                        r_idx <= r_idx + 6'd1;
                        if (r_en[w_i] && r_period[w_i] != 32'd0 && w_sub >= r_period[w_i])
                        begin
                            r_lastrun[w_i] <= r_run;
                            r_ov    <= 1'b1;
                            r_okind <= KIND_TASK;
                            r_oslot <= 4'(r_idx + 6'd1);
                            r_ook   <= 1'b1;
                            r_oread <= 32'd0;
                            r_ohalt <= 1'b0;
                            r_olast <= 1'b0;
                        end
                    end
                end
                S_END: begin
                    r_ov    <= 1'b1;
                    r_okind <= KIND_END;
                    r_oslot <= 4'd0;
                    r_ook   <= 1'b1;
                    r_oread <= r_run;
                    r_ohalt <= 1'b0;
                    r_olast <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid   = r_ov;
    assign o_kind    = r_okind;
    assign o_slot    = r_oslot;
    assign o_ok      = r_ook || w_isdone;
    assign o_reading = r_oread;
    assign o_halted  = r_ohalt;
    assign o_last    = r_olast;

    `PTS_ASSERT_NXT(a_cmd_reply, i_clk, i_rst_n, r_state == S_CMD, o_valid && o_last)
    `PTS_ASSERT_IMP(a_halt_end, i_clk, i_rst_n, o_valid && o_halted, o_kind == KIND_END && o_last)
    `PTS_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state == S_TMR, busy)
endmodule
